[src/rcpwc_pkg.sv]
package rcpwc_pkg;

  localparam int unsigned CHANNELS   = 6;
  localparam int unsigned TIMER_BITS = 16;
  localparam int unsigned CFG_W      = 16;
  localparam int unsigned CFG_IDX_W  = 1;

  localparam logic [CFG_W-1:0] PULSE_MIN_RST = CFG_W'(1000);
  localparam logic [CFG_W-1:0] PULSE_MAX_RST = CFG_W'(2000);

  typedef enum logic [0:0] {
    OP_EDGE = 1'b0,
    OP_READ = 1'b1
  } opcode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PULSE_MIN = 1'b0,
    REG_PULSE_MAX = 1'b1
  } cfg_reg_e;

  typedef logic [TIMER_BITS-1:0] stamp_t;
  typedef logic [CHANNELS-1:0]   chan_mask_t;

  typedef struct packed {
    logic       opcode;
    stamp_t     timestamp;
    chan_mask_t pin_levels;
    chan_mask_t edge_mask;
  } in_item_t;

  typedef struct packed {
    stamp_t [CHANNELS-1:0] width;
    chan_mask_t            updated_mask;
  } out_item_t;

  // Clamp to [lo, hi], then subtract lo; anything left below lo reads as zero.
  function automatic stamp_t clamp_offset(stamp_t w, logic [CFG_W-1:0] lo,
                                          logic [CFG_W-1:0] hi);
    stamp_t v;
    if (w < lo) begin
      v = lo;
    end else if (w > hi) begin
      v = hi;
    end else begin
      v = w;
    end
    if (v < lo) begin
      return '0;
    end
    return stamp_t'(v - lo);
  endfunction

endpackage

[src/rcpwc_in_if.sv]
interface rcpwc_in_if import rcpwc_pkg::*; ();
  logic       valid;
  logic       ready;
  logic       opcode;
  stamp_t     timestamp;
  chan_mask_t pin_levels;
  chan_mask_t edge_mask;

  modport source (output valid, output opcode, output timestamp, output pin_levels,
                  output edge_mask, input ready);
  modport sink   (input valid, input opcode, input timestamp, input pin_levels,
                  input edge_mask, output ready);
endinterface

[src/rcpwc_out_if.sv]
interface rcpwc_out_if import rcpwc_pkg::*; ();
  logic       valid;
  logic       ready;
  stamp_t     chan0_width;
  stamp_t     chan1_width;
  stamp_t     chan2_width;
  stamp_t     chan3_width;
  stamp_t     chan4_width;
  stamp_t     chan5_width;
  chan_mask_t updated_mask;

  modport source (output valid, output chan0_width, output chan1_width,
                  output chan2_width, output chan3_width, output chan4_width,
                  output chan5_width, output updated_mask, input ready);
  modport sink   (input valid, input chan0_width, input chan1_width,
                  input chan2_width, input chan3_width, input chan4_width,
                  input chan5_width, input updated_mask, output ready);
endinterface

[src/rc_pulse_width_capture.sv]
// Channel  Dir  Handshake          Payload
// in_i     in   valid/ready        opcode, timestamp, pin_levels, edge_mask
// out_o    out  valid/ready        chan0..chan5_width, updated_mask
// cfg      in   cfg_we_i (no wait) cfg_idx_i, cfg_data_i
//
// One item per cycle unless a read stalls: each item sits in the input register,
// where the channel state updates or a read result forms; a read result loads the
// output register once that register is free, and out_o.valid then rises.
// Reset clears starts, widths and update flags, and loads pulse_min/pulse_max.
// A read held by a stalled output blocks the input register; edge items never wait.
module rc_pulse_width_capture import rcpwc_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  rcpwc_in_if.sink             in_i,
  rcpwc_out_if.source          out_o,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i
);

  logic [CFG_W-1:0] pulse_min_q, pulse_max_q;

  logic       s1_valid_q;
  in_item_t   s1_q;
  logic       out_valid_q;
  out_item_t  out_q, out_d;

  stamp_t [CHANNELS-1:0] start_q, start_d;
  stamp_t [CHANNELS-1:0] width_q, width_d;
  chan_mask_t            flags_q, flags_d;

  logic out_free, s1_is_read, edge_done, read_done, s1_done, in_fire;

  assign out_free   = !out_valid_q || out_o.ready;
  assign s1_is_read = (s1_q.opcode == OP_READ);
  assign edge_done  = s1_valid_q && !s1_is_read;
  assign read_done  = s1_valid_q && s1_is_read && out_free;
  assign s1_done    = edge_done || read_done;
  assign in_i.ready = !s1_valid_q || s1_done;
  assign in_fire    = in_i.valid && in_i.ready;

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pulse_min_q <= PULSE_MIN_RST;
      pulse_max_q <= PULSE_MAX_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_PULSE_MIN: pulse_min_q <= cfg_data_i;
        REG_PULSE_MAX: pulse_max_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      s1_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_q.opcode     <= in_i.opcode;
      s1_q.timestamp  <= in_i.timestamp;
      s1_q.pin_levels <= in_i.pin_levels;
      s1_q.edge_mask  <= in_i.edge_mask;
    end
  end

  // channel state update
  always_comb begin
    start_d = start_q;
    width_d = width_q;
    flags_d = flags_q;
    if (edge_done) begin
      for (int i = 0; i < CHANNELS; i++) begin
        if (s1_q.edge_mask[i]) begin
          if (s1_q.pin_levels[i]) begin
            start_d[i] = s1_q.timestamp;
          end else if (s1_q.timestamp > start_q[i]) begin
            width_d[i] = stamp_t'(s1_q.timestamp - start_q[i]);
          end
        end
      end
      flags_d = flags_q | s1_q.edge_mask;
    end else if (read_done) begin
      flags_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q <= '0;
      width_q <= '0;
      flags_q <= '0;
    end else begin
      start_q <= start_d;
      width_q <= width_d;
      flags_q <= flags_d;
    end
  end

  // read result
  always_comb begin
    for (int i = 0; i < CHANNELS; i++) begin
      out_d.width[i] = clamp_offset(width_q[i], pulse_min_q, pulse_max_q);
    end
    out_d.updated_mask = flags_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= read_done;
    end
  end

  always_ff @(posedge clk_i) begin
    if (read_done) begin
      out_q <= out_d;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.chan0_width  = out_q.width[0];
  assign out_o.chan1_width  = out_q.width[1];
  assign out_o.chan2_width  = out_q.width[2];
  assign out_o.chan3_width  = out_q.width[3];
  assign out_o.chan4_width  = out_q.width[4];
  assign out_o.chan5_width  = out_q.width[5];
  assign out_o.updated_mask = out_q.updated_mask;

  a_read_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    read_done |=> out_valid_q)
    else $error("read item did not produce a result");

  a_read_mask: assert property (@(posedge clk_i) disable iff (!rst_ni)
    read_done |=> (out_q.updated_mask == $past(flags_q)) && (flags_q == '0))
    else $error("read result mask wrong or flags not cleared");

  a_edge_sets_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    edge_done |=> (($past(s1_q.edge_mask) & ~flags_q) == '0))
    else $error("edge item did not set its update flags");

  a_empty_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s1_valid_q |-> in_i.ready)
    else $error("input stalled while input register empty");

endmodule
